[hdl/lr_pkg.sv]
package lr_pkg;

   // Coordinate width used when the top level is not overridden (8 to 16).
   localparam int DEFAULT_COORD_BITS = 12;

   localparam int COLOR_BITS = 16;

   // Command queue between setup and stepper, and result queue at the output.
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic {
      MODE_START   = 1'b0,
      MODE_ADVANCE = 1'b1
   } mode_type;

endpackage

[hdl/lr_fifo.sv]
module lr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                full;
   logic                do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];

   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/lr_front.sv]
module lr_front #(
   parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_mode,
   input  logic signed [COORD_BITS-1:0]  in_start_x,
   input  logic signed [COORD_BITS-1:0]  in_start_y,
   input  logic signed [COORD_BITS-1:0]  in_end_x,
   input  logic signed [COORD_BITS-1:0]  in_end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0] in_color,
   output logic [1:0]                    in_flight,
   output logic                          out_valid,
   output logic                          out_is_start,
   output logic signed [COORD_BITS-1:0]  out_x1,
   output logic signed [COORD_BITS-1:0]  out_y1,
   output logic [COORD_BITS:0]           out_dx,
   output logic [COORD_BITS:0]           out_dy,
   output logic                          out_sxn,
   output logic                          out_syn,
   output logic                          out_xmaj,
   output logic signed [COORD_BITS+2:0]  out_err0,
   output logic [lr_pkg::COLOR_BITS-1:0] out_color
);

   localparam int C = COORD_BITS;
   localparam int E = COORD_BITS + 3;

   // stage 1: absolute deltas and step directions
   logic                          s1_valid_ff;
   logic                          s1_start_ff, s1_start_in;
   logic signed [C-1:0]           s1_x1_ff, s1_y1_ff;
   logic [C:0]                    s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic                          s1_sxn_ff, s1_sxn_in, s1_syn_ff, s1_syn_in;
   logic [lr_pkg::COLOR_BITS-1:0] s1_color_ff;

   // stage 2: major axis and first error term
   logic                          s2_valid_ff;
   logic                          s2_start_ff;
   logic signed [C-1:0]           s2_x1_ff, s2_y1_ff;
   logic [C:0]                    s2_dx_ff, s2_dy_ff;
   logic                          s2_sxn_ff, s2_syn_ff;
   logic                          s2_xmaj_ff, s2_xmaj_in;
   logic signed [E-1:0]           s2_err0_ff, s2_err0_in;
   logic [lr_pkg::COLOR_BITS-1:0] s2_color_ff;

   logic signed [C:0] x1_ext, y1_ext, x2_ext, y2_ext;
   logic              x_gt, y_gt;
   logic [C:0]        major, minor;

   always_comb begin
      x1_ext      = {in_start_x[C-1], in_start_x};
      y1_ext      = {in_start_y[C-1], in_start_y};
      x2_ext      = {in_end_x[C-1], in_end_x};
      y2_ext      = {in_end_y[C-1], in_end_y};
      x_gt        = (in_end_x > in_start_x);
      y_gt        = (in_end_y > in_start_y);
      s1_dx_in    = x_gt ? (x2_ext - x1_ext) : (x1_ext - x2_ext);
      s1_dy_in    = y_gt ? (y2_ext - y1_ext) : (y1_ext - y2_ext);
      s1_sxn_in   = ~x_gt;
      s1_syn_in   = ~y_gt;
      s1_start_in = (lr_pkg::mode_type'(in_mode) == lr_pkg::MODE_START);
   end

   always_comb begin
      s2_xmaj_in = (s1_dx_ff > s1_dy_ff);
      major      = s2_xmaj_in ? s1_dx_ff : s1_dy_ff;
      minor      = s2_xmaj_in ? s1_dy_ff : s1_dx_ff;
      // error after its first gain: 2*minor - major
      s2_err0_in = {1'b0, minor, 1'b0} - {2'b00, major};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_start_ff <= s1_start_in;
      s1_x1_ff    <= in_start_x;
      s1_y1_ff    <= in_start_y;
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s1_sxn_ff   <= s1_sxn_in;
      s1_syn_ff   <= s1_syn_in;
      s1_color_ff <= in_color;

      s2_start_ff <= s1_start_ff;
      s2_x1_ff    <= s1_x1_ff;
      s2_y1_ff    <= s1_y1_ff;
      s2_dx_ff    <= s1_dx_ff;
      s2_dy_ff    <= s1_dy_ff;
      s2_sxn_ff   <= s1_sxn_ff;
      s2_syn_ff   <= s1_syn_ff;
      s2_xmaj_ff  <= s2_xmaj_in;
      s2_err0_ff  <= s2_err0_in;
      s2_color_ff <= s1_color_ff;
   end

   assign in_flight    = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};
   assign out_valid    = s2_valid_ff;
   assign out_is_start = s2_start_ff;
   assign out_x1       = s2_x1_ff;
   assign out_y1       = s2_y1_ff;
   assign out_dx       = s2_dx_ff;
   assign out_dy       = s2_dy_ff;
   assign out_sxn      = s2_sxn_ff;
   assign out_syn      = s2_syn_ff;
   assign out_xmaj     = s2_xmaj_ff;
   assign out_err0     = s2_err0_ff;
   assign out_color    = s2_color_ff;

endmodule

[hdl/lr_back.sv]
module lr_back #(
   parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_avail,
   input  logic                          cmd_is_start,
   input  logic signed [COORD_BITS-1:0]  cmd_x1,
   input  logic signed [COORD_BITS-1:0]  cmd_y1,
   input  logic [COORD_BITS:0]           cmd_dx,
   input  logic [COORD_BITS:0]           cmd_dy,
   input  logic                          cmd_sxn,
   input  logic                          cmd_syn,
   input  logic                          cmd_xmaj,
   input  logic signed [COORD_BITS+2:0]  cmd_err0,
   input  logic [lr_pkg::COLOR_BITS-1:0] cmd_color,
   input  logic                          rsp_full,
   output logic                          cmd_pop,
   output logic                          pix_push,
   output logic signed [COORD_BITS-1:0]  pix_x,
   output logic signed [COORD_BITS-1:0]  pix_y,
   output logic [lr_pkg::COLOR_BITS-1:0] pix_color,
   output logic                          pix_last
);

   localparam int C = COORD_BITS;
   localparam int E = COORD_BITS + 3;

   logic                          busy_ff, busy_in;
   logic signed [C-1:0]           cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C:0]                    dx_ff, dy_ff, rem_ff, rem_in;
   logic                          sxn_ff, syn_ff, xmaj_ff;
   logic signed [E-1:0]           err_ff, err_in;
   logic [lr_pkg::COLOR_BITS-1:0] color_ff;

   logic                go, start, active, last, moving;
   logic                sel_xmaj, sel_sxn, sel_syn;
   logic [C:0]          sel_dx, sel_dy, major, minor;
   logic signed [C-1:0] base_x, base_y, step_x, step_y;
   logic signed [E-1:0] err_base, err_gain, err_t, err_dn;
   logic                err_ge;

   always_comb begin
      go      = cmd_avail & ~rsp_full;
      start   = cmd_is_start;
      active  = go & (start | busy_ff);
      cmd_pop = go;

      sel_xmaj = start ? cmd_xmaj : xmaj_ff;
      sel_dx   = start ? cmd_dx   : dx_ff;
      sel_dy   = start ? cmd_dy   : dy_ff;
      sel_sxn  = start ? cmd_sxn  : sxn_ff;
      sel_syn  = start ? cmd_syn  : syn_ff;
      base_x   = start ? cmd_x1   : cur_x_ff;
      base_y   = start ? cmd_y1   : cur_y_ff;
      major    = sel_xmaj ? sel_dx : sel_dy;
      minor    = sel_xmaj ? sel_dy : sel_dx;

      rem_in = start ? major : rem_ff - 1'b1;
      last   = (rem_in == '0);
      moving = active & ~last;

      // the start command already carries the gained error term
      err_base = start ? cmd_err0 : err_ff;
      err_gain = start ? '0 : {1'b0, minor, 1'b0};
      err_t    = err_base + err_gain;
      err_dn   = err_base + err_gain - {1'b0, major, 1'b0};
      err_ge   = ~err_t[E-1];

      step_x = sel_sxn ? base_x - 1'b1 : base_x + 1'b1;
      step_y = sel_syn ? base_y - 1'b1 : base_y + 1'b1;

      busy_in  = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      if (active) begin
         busy_in = ~last;
      end
      if (moving) begin
         cur_x_in = (sel_xmaj | err_ge) ? step_x : base_x;
         cur_y_in = (~sel_xmaj | err_ge) ? step_y : base_y;
         err_in   = err_ge ? err_dn : err_t;
      end

      pix_push  = active;
      pix_x     = base_x;
      pix_y     = base_y;
      pix_color = start ? cmd_color : color_ff;
      pix_last  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      if (active) begin
         rem_ff <= rem_in;
      end
      if (go & start) begin
         dx_ff    <= cmd_dx;
         dy_ff    <= cmd_dy;
         sxn_ff   <= cmd_sxn;
         syn_ff   <= cmd_syn;
         xmaj_ff  <= cmd_xmaj;
         color_ff <= cmd_color;
      end
   end

endmodule

[hdl/line_rasterizer.sv]
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-------------------------------------------
// req_     | in        | req_push / req_full   | mode, start_x/y, end_x/y, pixel_color
// rsp_     | out       | rsp_pop / rsp_empty   | pixel_x, pixel_y, out_color, last_pixel
//
// One transaction per clock on both sides unless held by req_full or rsp_empty; a start,
// or an advance while a line is in progress, has its pixel on the rsp_ ports after the two
// setup stages, the command queue, the combinational stepper and the result queue.
// The stepper's single error add/compare per pixel gives one pixel a clock unless rq_full.
// Reset is synchronous: queues empty, no line in progress.
// req_full rises when the command queue plus setup stages hold CMD_QUEUE_DEPTH
// transactions; the stepper halts while the result queue is full.
module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::DEFAULT_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_mode,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0] req_pixel_color,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0] rsp_out_color,
   output logic                          rsp_last_pixel
);

   localparam int C         = COORD_BITS;
   localparam int E         = COORD_BITS + 3;
   localparam int CB        = lr_pkg::COLOR_BITS;
   localparam int CMD_DEPTH = lr_pkg::CMD_QUEUE_DEPTH;
   localparam int RSP_DEPTH = lr_pkg::RSP_QUEUE_DEPTH;
   // start flag, x1, y1, dx, dy, step signs, major axis, error, color
   localparam int CMD_WIDTH = 1 + 2 * C + 2 * (C + 1) + 3 + E + CB;
   localparam int PIX_WIDTH = 2 * C + CB + 1;
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);
   localparam int CREDIT_BITS  = CMD_CNT_BITS + 2;
   localparam logic [CREDIT_BITS-1:0] CREDIT_LIMIT = CREDIT_BITS'(CMD_DEPTH);
   localparam logic [RSP_CNT_BITS-1:0] RSP_FULL_CNT = RSP_CNT_BITS'(RSP_DEPTH);

   logic req_accept;

   // front -> command queue
   logic [1:0]          fr_in_flight;
   logic                fr_valid, fr_is_start, fr_sxn, fr_syn, fr_xmaj;
   logic signed [C-1:0] fr_x1, fr_y1;
   logic [C:0]          fr_dx, fr_dy;
   logic signed [E-1:0] fr_err0;
   logic [CB-1:0]       fr_color;

   // command queue -> back
   logic [CMD_WIDTH-1:0]    cq_in_data, cq_out_data;
   logic                    cq_empty, cq_pop;
   logic [CMD_CNT_BITS-1:0] cq_count;
   logic                    bk_is_start, bk_sxn, bk_syn, bk_xmaj;
   logic signed [C-1:0]     bk_x1, bk_y1;
   logic [C:0]              bk_dx, bk_dy;
   logic signed [E-1:0]     bk_err0;
   logic [CB-1:0]           bk_color;

   // back -> result queue
   logic                    pix_push, pix_last, rq_full;
   logic signed [C-1:0]     pix_x, pix_y;
   logic [CB-1:0]           pix_color;
   logic [PIX_WIDTH-1:0]    rq_in_data, rq_out_data;
   logic [RSP_CNT_BITS-1:0] rq_count;

   logic [CREDIT_BITS-1:0] credit_used;

   // Setup stages never stall: a transaction is only taken when the command
   // queue has room for it and for everything already in the setup stages.
   assign credit_used = CREDIT_BITS'(cq_count) + CREDIT_BITS'(fr_in_flight);
   assign req_full    = (credit_used >= CREDIT_LIMIT);
   assign req_accept  = req_push & ~req_full;

   lr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_accept),
      .in_mode      (req_mode),
      .in_start_x   (req_start_x),
      .in_start_y   (req_start_y),
      .in_end_x     (req_end_x),
      .in_end_y     (req_end_y),
      .in_color     (req_pixel_color),
      .in_flight    (fr_in_flight),
      .out_valid    (fr_valid),
      .out_is_start (fr_is_start),
      .out_x1       (fr_x1),
      .out_y1       (fr_y1),
      .out_dx       (fr_dx),
      .out_dy       (fr_dy),
      .out_sxn      (fr_sxn),
      .out_syn      (fr_syn),
      .out_xmaj     (fr_xmaj),
      .out_err0     (fr_err0),
      .out_color    (fr_color)
   );

   assign cq_in_data = {fr_is_start, fr_x1, fr_y1, fr_dx, fr_dy,
                        fr_sxn, fr_syn, fr_xmaj, fr_err0, fr_color};

   // The credit check keeps the command queue from overflowing.
   lr_fifo #(
      .WIDTH(CMD_WIDTH),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (cq_in_data),
      .pop       (cq_pop),
      .pop_data  (cq_out_data),
      .empty     (cq_empty),
      .count     (cq_count)
   );

   assign {bk_is_start, bk_x1, bk_y1, bk_dx, bk_dy,
           bk_sxn, bk_syn, bk_xmaj, bk_err0, bk_color} = cq_out_data;

   lr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_avail    (~cq_empty),
      .cmd_is_start (bk_is_start),
      .cmd_x1       (bk_x1),
      .cmd_y1       (bk_y1),
      .cmd_dx       (bk_dx),
      .cmd_dy       (bk_dy),
      .cmd_sxn      (bk_sxn),
      .cmd_syn      (bk_syn),
      .cmd_xmaj     (bk_xmaj),
      .cmd_err0     (bk_err0),
      .cmd_color    (bk_color),
      .rsp_full     (rq_full),
      .cmd_pop      (cq_pop),
      .pix_push     (pix_push),
      .pix_x        (pix_x),
      .pix_y        (pix_y),
      .pix_color    (pix_color),
      .pix_last     (pix_last)
   );

   assign rq_in_data = {pix_x, pix_y, pix_color, pix_last};

   // Result queue decouples the stepper from the consumer's pop; the stepper
   // halts while it is full.
   assign rq_full = (rq_count == RSP_FULL_CNT);

   lr_fifo #(
      .WIDTH(PIX_WIDTH),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pix_push),
      .push_data (rq_in_data),
      .pop       (rsp_pop),
      .pop_data  (rq_out_data),
      .empty     (rsp_empty),
      .count     (rq_count)
   );

   assign {rsp_pixel_x, rsp_pixel_y, rsp_out_color, rsp_last_pixel} = rq_out_data;

endmodule

[sim/line_rasterizer_tb.sv]
module line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB           = lr_pkg::DEFAULT_COORD_BITS;
   localparam int COORD_MIN    = -(1 << (CB - 1));
   localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
   // Leave some margin after the last pixel.
   localparam int DRAIN_CYCLES = 16;
   // Hold-off on the pixel side for the back-pressure test.
   localparam int HOLD_CYCLES  = 300;
   // Watchdog limit, well above the slowest legal run.
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic [lr_pkg::COLOR_BITS-1:0] color_type;

   typedef struct {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT ports. Every input starts at a known value.
   // ---------------------------------------------------------------------------
   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_push = 1'b0;
   logic      req_full;
   logic      req_mode = lr_pkg::MODE_ADVANCE;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   color_type req_pixel_color = '0;
   logic      rsp_empty;
   logic      rsp_pop = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   color_type rsp_out_color;
   logic      rsp_last_pixel;

   always #4 clock = ~clock;

   line_rasterizer #(.COORD_BITS(CB)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_pixel_color (req_pixel_color),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_out_color   (rsp_out_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   // ---------------------------------------------------------------------------
   // Traffic shaping knobs, set per test.
   // ---------------------------------------------------------------------------
   int   send_idle_pct = 0;     // chance per cycle that the sender sits idle
   int   pop_stall_pct = 0;     // chance per cycle that the receiver does not pop
   logic hold_request = 1'b0;   // test asks for a long receiver hold-off
   logic rsp_hold = 1'b0;       // receiver held off (driven by the hold-off timer)

   int   failures = 0;
   int   pixels_predicted = 0;
   int   cycle_count = 0;

   pixel_type pixels_due[$];    // pixels the line engine must still produce, oldest first

   // ---------------------------------------------------------------------------
   // Line tracer: our own copy of the Bresenham state.
   // ---------------------------------------------------------------------------
   logic      line_busy = 1'b0;
   coord_type pen_x = '0;
   coord_type pen_y = '0;
   int        span_x = 0;
   int        span_y = 0;
   logic      x_backward = 1'b0;
   logic      y_backward = 1'b0;
   logic      x_is_major = 1'b0;
   int        slope_err = 0;
   int        pixels_left = 0;
   color_type pen_color = '0;

   // One Bresenham step: major axis always moves, minor axis when the error
   // term reaches zero or more. Coordinates wrap at CB bits by truncation.
   function automatic void advance_pen();
      int sx;
      int sy;
      sx = x_backward ? -1 : 1;
      sy = y_backward ? -1 : 1;
      if (x_is_major) begin
         pen_x = coord_type'(int'(pen_x) + sx);
         slope_err += 2 * span_y;
         if (slope_err >= 0) begin
            pen_y = coord_type'(int'(pen_y) + sy);
            slope_err -= 2 * span_x;
         end
      end else begin
         pen_y = coord_type'(int'(pen_y) + sy);
         slope_err += 2 * span_x;
         if (slope_err >= 0) begin
            pen_x = coord_type'(int'(pen_x) + sx);
            slope_err -= 2 * span_y;
         end
      end
   endfunction

   // Emit the pixel under the pen, then step if the line goes on.
   function automatic void emit_pen_pixel();
      pixel_type p;
      p.x = pen_x;
      p.y = pen_y;
      p.color = pen_color;
      p.last = (pixels_left == 0);
      pixels_due.push_back(p);
      pixels_predicted++;
      line_busy = !p.last;
      if (line_busy)
         advance_pen();
   endfunction

   // Work out the pixel (if any) that one accepted transaction produces.
   function automatic void trace_line(input lr_pkg::mode_type m, input coord_type x1,
                                      input coord_type y1, input coord_type x2,
                                      input coord_type y2, input color_type c);
      int ix1;
      int iy1;
      int ix2;
      int iy2;
      ix1 = x1;
      iy1 = y1;
      ix2 = x2;
      iy2 = y2;
      if (m == lr_pkg::MODE_START) begin
         span_x = (ix2 > ix1) ? ix2 - ix1 : ix1 - ix2;
         span_y = (iy2 > iy1) ? iy2 - iy1 : iy1 - iy2;
         // Equal endpoints step backward, but that axis never moves.
         x_backward = !(ix2 > ix1);
         y_backward = !(iy2 > iy1);
         x_is_major = span_x > span_y;      // ties go to y
         pixels_left = x_is_major ? span_x : span_y;
         slope_err = -pixels_left;
         pen_x = x1;
         pen_y = y1;
         pen_color = c;
         emit_pen_pixel();
      end else if (line_busy) begin
         pixels_left--;
         emit_pen_pixel();
      end
      // advance with no line running: nothing comes out
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: one transaction on the request queue, then a random idle gap.
   // ---------------------------------------------------------------------------
   task automatic send_item(input lr_pkg::mode_type m, input coord_type x1,
                            input coord_type y1, input coord_type x2,
                            input coord_type y2, input color_type c);
      int gap;
      gap = 0;
      req_push <= 1'b1;
      req_mode <= m;
      req_start_x <= x1;
      req_start_y <= y1;
      req_end_x <= x2;
      req_end_y <= y2;
      req_pixel_color <= c;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      trace_line(m, x1, y1, x2, y2, c);
      while (gap < 60 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Advance; endpoint and color fields carry junk the block must ignore.
   task automatic send_advance();
      send_item(lr_pkg::MODE_ADVANCE, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), color_type'($urandom));
   endtask

   task automatic send_start(input coord_type x1, input coord_type y1, input coord_type x2,
                             input coord_type y2, input color_type c);
      send_item(lr_pkg::MODE_START, x1, y1, x2, y2, c);
   endtask

   // Random coordinate, with the range ends picked now and then.
   function automatic coord_type pick_coord();
      int r;
      r = $urandom_range(19);
      if (r == 0)
         return coord_type'(COORD_MIN);
      if (r == 1)
         return coord_type'(COORD_MAX);
      return coord_type'($urandom);
   endfunction

   // Coordinate close to c, kept inside the range so short lines stay short.
   function automatic coord_type pick_near(input coord_type c);
      int v;
      v = int'(c) + $urandom_range(40) - 20;
      if (v < COORD_MIN)
         v = COORD_MIN;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return coord_type'(v);
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver and pixel checker. Outputs and rsp_pop are sampled at the edge,
   // before this edge's updates land; the next pop is chosen with an NBA.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pixels_due.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d color=%h last=%b",
                   rsp_pixel_x, rsp_pixel_y, rsp_out_color, rsp_last_pixel);
            failures++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_pixel_x !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
               failures++;
            end
            if (rsp_pixel_y !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
               failures++;
            end
            if (rsp_out_color !== want.color) begin
               $error("out_color: expected %h, got %h", want.color, rsp_out_color);
               failures++;
            end
            if (rsp_last_pixel !== want.last) begin
               $error("last_pixel: expected %b, got %b", want.last, rsp_last_pixel);
               failures++;
            end
         end
      end
      rsp_pop <= !rsp_hold && ($urandom_range(99) >= pop_stall_pct);
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   always begin : hold_off_timer
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
      hold_request = 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Advance right after reset: no line, no pixel.
   task automatic test_advance_when_idle();
      send_advance();
      send_advance();
   endtask

   // Start equal to end: one pixel marked last, then the block is idle again.
   task automatic test_single_pixel();
      send_start(coord_type'(COORD_MIN), coord_type'(COORD_MAX), coord_type'(COORD_MIN),
                 coord_type'(COORD_MAX), 16'hFFFF);
      send_advance();
   endtask

   // Horizontal and vertical lines; one axis stays put. Extra advance past the end.
   task automatic test_axis_lines();
      send_start(coord_type'(COORD_MAX), coord_type'(COORD_MIN), coord_type'(COORD_MAX - 3),
                 coord_type'(COORD_MIN), 16'h0000);
      repeat (4) send_advance();
      send_start(coord_type'(0), coord_type'(COORD_MAX), coord_type'(0),
                 coord_type'(COORD_MAX - 2), 16'h8001);
      repeat (2) send_advance();
   endtask

   // 45-degree tie (y major) and a steep line stepping x backward.
   task automatic test_diagonals();
      send_start(coord_type'(0), coord_type'(0), coord_type'(2), coord_type'(2), 16'h1234);
      repeat (2) send_advance();
      send_start(coord_type'(5), coord_type'(-3), coord_type'(3), coord_type'(2), 16'h7FFE);
      repeat (5) send_advance();
   endtask

   // Full-range diagonal cut short by a new start.
   task automatic test_restart_while_busy();
      send_start(coord_type'(COORD_MIN), coord_type'(COORD_MIN), coord_type'(COORD_MAX),
                 coord_type'(COORD_MAX), 16'hA5A5);
      repeat (2) send_advance();
      send_start(coord_type'(-1), coord_type'(1), coord_type'(3), coord_type'(-1), 16'h5A5A);
      repeat (2) send_advance();
   endtask

   // Receiver holds off while a long line is pushed: queues fill, req_full stalls us.
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      hold_request = 1'b1;
      send_start(coord_type'(-150), coord_type'(100), coord_type'(150), coord_type'(-50),
                 16'h5A3C);
      repeat (300) send_advance();
   endtask

   // Mostly complete short lines with random content; some overrun, some broken
   // off by a restart, a few long lines cut short, and some noise.
   task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                    input int pixel_goal);
      int        first_count;
      int        kind;
      int        major;
      int        steps;
      int        r;
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      first_count = pixels_predicted;
      while (pixels_predicted - first_count < pixel_goal) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            repeat ($urandom_range(1, 3))
               send_item(lr_pkg::mode_type'($urandom_range(1)), coord_type'($urandom),
                         coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom), color_type'($urandom));
         end else begin
            x1 = pick_coord();
            y1 = pick_coord();
            if (kind < 90) begin
               x2 = pick_near(x1);
               y2 = pick_near(y1);
            end else begin
               x2 = pick_coord();
               y2 = pick_coord();
            end
            major = (int'(x2) > int'(x1)) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
            r = (int'(y2) > int'(y1)) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
            if (r > major)
               major = r;
            send_start(x1, y1, x2, y2, color_type'($urandom));
            if (kind < 90) begin
               r = $urandom_range(9);
               if (r < 7)
                  steps = major;
               else if (r < 9)
                  steps = major + $urandom_range(1, 3);
               else
                  steps = $urandom_range(0, major);
            end else begin
               steps = $urandom_range(0, 24);
            end
            repeat (steps) send_advance();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_advance_when_idle();
      test_single_pixel();
      test_axis_lines();
      test_diagonals();
      test_restart_while_busy();
      test_backpressure();
      test_random_lines(0, 0, 300);
      test_random_lines(73, 0, 300);
      test_random_lines(0, 73, 300);
      test_random_lines(22, 22, 300);

      req_push <= 1'b0;
      while (pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
